FILE: rtl/rme_pkg.sv
// Package with the widths, register addresses and shared types of the modular exponentiator.
package rme_pkg;

    localparam int KEY_WIDTH = 16;
    localparam int MSG_WIDTH = 32;
    localparam int MSG_CNT_W = $clog2(MSG_WIDTH);
    localparam int KEY_CNT_W = $clog2(KEY_WIDTH);
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS = 1'b1;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] remainder;
        logic [KEY_WIDTH-1:0] addend;
        logic                 add_en;
        logic [KEY_WIDTH-1:0] modulus;
    } step_req_t;

endpackage

FILE: rtl/rme_mod_step.sv
// Shared modular step unit: (2 * remainder + add_en * addend) mod modulus.
module rme_mod_step
    import rme_pkg::*;
(
    input  step_req_t            req,
    output logic [KEY_WIDTH-1:0] rem
);

    logic [KEY_WIDTH:0] dbl;
    logic [KEY_WIDTH:0] dbl_red;
    logic [KEY_WIDTH:0] sum;
    logic [KEY_WIDTH:0] sum_red;
    logic [KEY_WIDTH:0] mod_ext;

    // The remainder and the addend are both below the modulus, so one
    // conditional subtraction after each of the two steps suffices.
    always_comb
    begin
        mod_ext = {1'b0, req.modulus};
        dbl = {req.remainder, 1'b0};
        if (dbl >= mod_ext)
        begin
            dbl_red = dbl - mod_ext;
        end
        else
        begin
            dbl_red = dbl;
        end
        if (req.add_en)
        begin
            sum = {1'b0, dbl_red[KEY_WIDTH-1:0]} + {1'b0, req.addend};
        end
        else
        begin
            sum = {1'b0, dbl_red[KEY_WIDTH-1:0]};
        end
        if (sum >= mod_ext)
        begin
            sum_red = sum - mod_ext;
        end
        else
        begin
            sum_red = sum;
        end
        rem = sum_red[KEY_WIDTH-1:0];
    end

endmodule

FILE: rtl/rme_core.sv
// Sequencer that drives the shared modular step unit through reduction and square-and-multiply.
module rme_core
    import rme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MSG_WIDTH-1:0] message,
    input  logic [KEY_WIDTH-1:0] exponent,
    input  logic [KEY_WIDTH-1:0] modulus,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KEY_WIDTH-1:0] result,
    output logic                 modulus_error
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT,
        S_DONE
    } state_t;

    localparam logic [MSG_CNT_W-1:0] MSG_LAST = MSG_CNT_W'(MSG_WIDTH - 1);
    localparam logic [KEY_CNT_W-1:0] KEY_LAST = KEY_CNT_W'(KEY_WIDTH - 1);

    state_t               state_reg, state_next;
    logic [MSG_WIDTH-1:0] msg_reg, msg_next;
    logic [KEY_WIDTH-1:0] base_reg, base_next;
    logic [KEY_WIDTH-1:0] acc_reg, acc_next;
    logic [KEY_WIDTH-1:0] part_reg, part_next;
    logic [MSG_CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_CNT_W-1:0] ebit_reg, ebit_next;
    logic                 err_reg, err_next;
    logic                 out_valid_reg, out_valid_next;
    logic [KEY_WIDTH-1:0] result_reg, result_next;
    logic                 out_err_reg, out_err_next;

    step_req_t            step_req;
    logic [KEY_WIDTH-1:0] step_rem;

    rme_mod_step u_step (
        .req (step_req),
        .rem (step_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        msg_next = msg_reg;
        base_next = base_reg;
        acc_next = acc_reg;
        part_next = part_reg;
        cnt_next = cnt_reg;
        ebit_next = ebit_reg;
        err_next = err_reg;
        result_next = result_reg;
        out_err_next = out_err_reg;
        out_valid_next = out_valid_reg && out_stall;

        step_req.remainder = part_reg;
        step_req.addend = acc_reg;
        step_req.add_en = 1'b0;
        step_req.modulus = modulus;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    err_next = 1'b0;
                    if (modulus == '0)
                    begin
                        acc_next = '0;
                        err_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (exponent == '0)
                    begin
                        acc_next = KEY_WIDTH'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        msg_next = message;
                        part_next = '0;
                        cnt_next = MSG_LAST;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                step_req.addend = KEY_WIDTH'(1);
                step_req.add_en = msg_reg[cnt_reg];
                part_next = step_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    base_next = step_rem;
                    acc_next = (modulus == KEY_WIDTH'(1)) ? '0 : KEY_WIDTH'(1);
                    part_next = '0;
                    cnt_next = MSG_CNT_W'(KEY_LAST);
                    ebit_next = KEY_LAST;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                step_req.add_en = acc_reg[cnt_reg[KEY_CNT_W-1:0]];
                part_next = step_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next = step_rem;
                    part_next = '0;
                    cnt_next = MSG_CNT_W'(KEY_LAST);
                    if (exponent[ebit_reg])
                    begin
                        state_next = S_MULT;
                    end
                    else if (ebit_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ebit_next = ebit_reg - 1'b1;
                    end
                end
            end
            S_MULT:
            begin
                step_req.add_en = base_reg[cnt_reg[KEY_CNT_W-1:0]];
                part_next = step_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next = step_rem;
                    part_next = '0;
                    cnt_next = MSG_CNT_W'(KEY_LAST);
                    if (ebit_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ebit_next = ebit_reg - 1'b1;
                        state_next = S_SQUARE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    result_next = acc_reg;
                    out_err_next = err_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            result_reg <= '0;
            out_err_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            result_reg <= result_next;
            out_err_reg <= out_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
        base_reg <= base_next;
        acc_reg <= acc_next;
        part_reg <= part_next;
        cnt_reg <= cnt_next;
        ebit_reg <= ebit_next;
        err_reg <= err_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign result = result_reg;
    assign modulus_error = out_err_reg;

endmodule

FILE: rtl/rsa_modular_exponentiation.sv
// Top level of the modular exponentiator with its register port.
//
// The input channel (in_valid, in_stall, message) takes one 32-bit message per
// transfer. The output channel (out_valid, out_stall, result, modulus_error)
// returns one result per message: (message mod n) to the power e, mod n.
// The exponent e and modulus n are written over the APB-style port at byte
// addresses 0 and 4; reads return their values. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A zero modulus gives result 0 with modulus_error set; a zero exponent gives 1.
// One shared step unit computes (2r + a) mod n per cycle. A message is first
// reduced bit by bit, then each of the 16 exponent bits costs a modular
// squaring, plus a modular multiply when the bit is set. A zero modulus or
// zero exponent skips these steps and goes straight to the result.
// in_stall stays high from the transfer until the result
// is loaded into the output register. A stalled result holds in that
// register, and the block can take the next message meanwhile.
// Reset sets the exponent to 1, the modulus to 65535 and empties the block.
module rsa_modular_exponentiation
    import rme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MSG_WIDTH-1:0] message,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KEY_WIDTH-1:0] result,
    output logic                 modulus_error,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    logic [KEY_WIDTH-1:0] exponent_reg, exponent_next;
    logic [KEY_WIDTH-1:0] modulus_reg, modulus_next;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        exponent_next = exponent_reg;
        modulus_next = modulus_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_EXPONENT: exponent_next = pwdata[KEY_WIDTH-1:0];
                REG_MODULUS:  modulus_next = pwdata[KEY_WIDTH-1:0];
                default:      exponent_next = exponent_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= KEY_WIDTH'(1);
            modulus_reg <= '1;
        end
        else
        begin
            exponent_reg <= exponent_next;
            modulus_reg <= modulus_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_EXPONENT: prdata = DATA_W'(exponent_reg);
            REG_MODULUS:  prdata = DATA_W'(modulus_reg);
            default:      prdata = '0;
        endcase
    end

    rme_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .message       (message),
        .exponent      (exponent_reg),
        .modulus       (modulus_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result        (result),
        .modulus_error (modulus_error)
    );

endmodule

FILE: rtl/rme_checker.sv
// Port-level checker for the modular exponentiator and its bind statement.
module rme_checker
    import rme_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [KEY_WIDTH-1:0] result,
    input logic                 modulus_error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Stalled result was dropped.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result) && $stable(modulus_error))
        else $error("Stalled result changed.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && modulus_error |-> result == '0)
        else $error("Flagged result is not zero.");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Block took no time after an input transfer.");

endmodule

bind rsa_modular_exponentiation rme_checker u_rme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result        (result),
    .modulus_error (modulus_error)
);

FILE: test/rsa_modular_exponentiation_test.sv
// Modular exponentiator testbench: directed and random messages against typed or predicted results.
module rsa_modular_exponentiation_test;
    import rme_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int RANDOM_MESSAGES = 580;
    localparam int TAIL_CYCLES = 600;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int IDLE_PERCENT = 29;
    localparam int DIRECTED_ROWS = 20;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] result;
        logic                 modulus_error;
    } power_result_t;

    typedef struct {
        bit                 set_keys;
        bit [DATA_W-1:0]    exponent_raw;
        bit [DATA_W-1:0]    modulus_raw;
        bit [MSG_WIDTH-1:0] msg;
        bit                 typed;
        bit [KEY_WIDTH-1:0] typed_result;
        bit                 typed_error;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [MSG_WIDTH-1:0] message = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KEY_WIDTH-1:0] result;
    logic                 modulus_error;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    logic [KEY_WIDTH-1:0] key_exponent = 16'd1;
    logic [KEY_WIDTH-1:0] key_modulus = 16'hFFFF;
    power_result_t        pending_results[$];
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    bit                   steady = 1'b0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 32'd1, 32'd65535, 32'h0000_0000, 1'b1, 16'd0, 1'b0},
        '{1'b0, 32'd1, 32'd65535, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0},
        '{1'b0, 32'd1, 32'd65535, 32'h0001_0000, 1'b1, 16'd1, 1'b0},
        '{1'b0, 32'd1, 32'd65535, 32'h0000_FFFE, 1'b1, 16'd65534, 1'b0},
        '{1'b1, 32'd7, 32'd0, 32'h0000_0005, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b1},
        '{1'b1, 32'd0, 32'd1, 32'h0000_0009, 1'b1, 16'd1, 1'b0},
        '{1'b1, 32'd0, 32'd65535, 32'h0000_0000, 1'b1, 16'd1, 1'b0},
        '{1'b1, 32'd9, 32'd1, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0},
        '{1'b1, 32'd65535, 32'd65535, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0},
        '{1'b0, 32'd65535, 32'd65535, 32'h0000_0001, 1'b1, 16'd1, 1'b0},
        '{1'b0, 32'd65535, 32'd65535, 32'h0000_0002, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'd65535, 32'd65521, 32'hDEAD_BEEF, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'd1, 32'd2, 32'hFFFF_FFFF, 1'b1, 16'd1, 1'b0},
        '{1'b1, 32'd17, 32'd3233, 32'h0000_0041, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'd2753, 32'd3233, 32'h0000_0AE6, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'hFFFF_0003, 32'hABCD_0007, 32'h0000_0002, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'h0000_8000, 32'd65535, 32'h0000_0003, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'd2, 32'd65535, 32'h0000_FFFE, 1'b0, 16'd0, 1'b0},
        '{1'b1, 32'd65535, 32'd65534, 32'h7FFF_FFFF, 1'b0, 16'd0, 1'b0}
    };

    rsa_modular_exponentiation dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .message(message),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result(result),
        .modulus_error(modulus_error),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic power_result_t predict_power(input logic [KEY_WIDTH-1:0] e,
                                                    input logic [KEY_WIDTH-1:0] n,
                                                    input logic [MSG_WIDTH-1:0] m);
        power_result_t r;
        logic [31:0]   acc;
        logic [31:0]   base;
        r = '0;
        if (n == '0)
        begin
            r.modulus_error = 1'b1;
        end
        else if (e == '0)
        begin
            r.result = 16'd1;
        end
        else
        begin
            base = m % n;
            acc = 32'd1 % n;
            for (int b = KEY_WIDTH - 1; b >= 0; b--)
            begin
                acc = (acc * acc) % n;
                if (e[b])
                    acc = (acc * base) % n;
            end
            r.result = acc[KEY_WIDTH-1:0];
        end
        return r;
    endfunction

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_key_register(input logic reg_code, input logic [KEY_WIDTH-1:0] want);
        logic [DATA_W-1:0] rdata;
        apb_access(1'b0, {reg_code, 2'b00}, '0, rdata);
        if (rdata !== {{(DATA_W-KEY_WIDTH){1'b0}}, want})
        begin
            $error("register %0d readback: expected %0d, got %0d", reg_code, want, rdata);
            mismatch_count++;
        end
    endtask

    task automatic write_keys(input logic [DATA_W-1:0] exponent_raw,
                              input logic [DATA_W-1:0] modulus_raw);
        logic [DATA_W-1:0] unused;
        apb_access(1'b1, {REG_EXPONENT, 2'b00}, exponent_raw, unused);
        key_exponent = exponent_raw[KEY_WIDTH-1:0];
        apb_access(1'b1, {REG_MODULUS, 2'b00}, modulus_raw, unused);
        key_modulus = modulus_raw[KEY_WIDTH-1:0];
        check_key_register(REG_EXPONENT, key_exponent);
        check_key_register(REG_MODULUS, key_modulus);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic send_message(input logic [MSG_WIDTH-1:0] msg, input power_result_t want);
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        in_valid <= 1'b1;
        message <= msg;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(want);
    endtask

    function automatic logic [KEY_WIDTH-1:0] pick_exponent();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'h8000 | 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_modulus();
        case ($urandom_range(11))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(255, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [MSG_WIDTH-1:0] pick_message();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom & 32'h0000_FFFF;
            4: return key_modulus * $urandom_range(65535) + $urandom_range(2);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        power_result_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: result %0d, modulus_error %0d",
                       result, modulus_error);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want.result)
                begin
                    $error("result: expected %0d, got %0d", want.result, result);
                    mismatch_count++;
                end
                if (modulus_error !== want.modulus_error)
                begin
                    $error("modulus_error: expected %0d, got %0d",
                           want.modulus_error, modulus_error);
                    mismatch_count++;
                end
            end
        end
        out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        power_result_t want;
        int            phase_left;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_key_register(REG_EXPONENT, key_exponent);
        check_key_register(REG_MODULUS, key_modulus);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_keys)
            begin
                drain_results();
                write_keys(directed_rows[i].exponent_raw, directed_rows[i].modulus_raw);
            end
            if (directed_rows[i].typed)
                want = '{directed_rows[i].typed_result, directed_rows[i].typed_error};
            else
                want = predict_power(key_exponent, key_modulus, directed_rows[i].msg);
            send_message(directed_rows[i].msg, want);
        end

        phase_left = 0;
        for (int i = 0; i < RANDOM_MESSAGES; i++)
        begin
            steady = (i >= 250 && i < 380);
            if (phase_left == 0)
            begin
                drain_results();
                write_keys({16'($urandom), pick_exponent()}, {16'($urandom), pick_modulus()});
                phase_left = $urandom_range(60, 20);
            end
            else if (i == 120)
            begin
                // The sender holds off until every outstanding result is back.
                drain_results();
            end
            phase_left--;
            message_step: begin
                logic [MSG_WIDTH-1:0] msg;
                msg = pick_message();
                send_message(msg, predict_power(key_exponent, key_modulus, msg));
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
